// ===== hw/rtl/adbd_pkg.sv =====
// Shared types, constants and arithmetic helpers for the anchor distance box decoder.
// No dependencies; imported by adbd_walk and anchor_distance_box_decode.
`timescale 1ns / 1ps
`default_nettype none

package adbd_pkg;

   localparam int ScoreW     = 16;
   localparam int DimW       = 13;
   localparam int RecipW     = 20;
   localparam int CellW      = 9;
   localparam int GridW      = 10;
   localparam int CountW     = 8;
   localparam int IndexW     = 7;
   localparam int OffsetW    = 16;
   localparam int ShiftW     = 3;
   localparam int LevelW     = 2;
   localparam int LaneCount  = 14;
   localparam int PointCount = 5;
   localparam int BoxLanes   = 4;
   localparam int PixW       = 25;
   localparam int ProdW      = PixW + RecipW + 1;
   localparam int RoundShift = 18;
   localparam int RoundW     = ProdW - RoundShift;
   localparam int CsrIndexW  = 3;
   localparam int CsrDataW   = 20;

   localparam logic [CsrIndexW-1:0] CsrScoreThreshold = 3'd0;
   localparam logic [CsrIndexW-1:0] CsrImageWidth     = 3'd1;
   localparam logic [CsrIndexW-1:0] CsrImageHeight    = 3'd2;
   localparam logic [CsrIndexW-1:0] CsrWidthRecip     = 3'd3;
   localparam logic [CsrIndexW-1:0] CsrHeightRecip    = 3'd4;

   localparam logic [GridW-1:0]  GridLimit = 10'd512;
   localparam logic [LevelW-1:0] LastLevel = 2'd2;
   localparam logic [ShiftW-1:0] BaseShift = 3'd3;

   localparam logic signed [ProdW-1:0]  RoundHalf = ProdW'(1) << (RoundShift - 1);
   localparam logic signed [RoundW-1:0] EdgeLow   = RoundW'(0);
   localparam logic signed [RoundW-1:0] SatLow    = RoundW'(-32768);
   localparam logic signed [RoundW-1:0] SatHigh   = RoundW'(32767);
   localparam logic signed [RoundW-1:0] OneQ214   = RoundW'(16384);

   typedef struct packed {
      logic [ScoreW-1:0] score_threshold;
      logic [DimW-1:0]   image_width;
      logic [DimW-1:0]   image_height;
      logic [RecipW-1:0] width_reciprocal;
      logic [RecipW-1:0] height_reciprocal;
   } cfg_type;

   typedef struct packed {
      logic [CellW-1:0]  column;
      logic [CellW-1:0]  row;
      logic [ShiftW-1:0] shift;
      logic [IndexW-1:0] face_index;
      logic              hit;
   } anchor_type;

   // Grid size of one level, held between one and the grid limit.
   function automatic logic [GridW-1:0] grid_dim(input logic [DimW-1:0] pixels,
                                                 input logic [ShiftW-1:0] shift);
      logic [DimW-1:0] n;
      n = pixels >> shift;
      if (n == '0) begin
         return GridW'(1);
      end
      if (n > DimW'(GridLimit)) begin
         return GridLimit;
      end
      return n[GridW-1:0];
   endfunction

   // Round a Q.32 product to Q2.14, nearest with ties toward plus infinity.
   function automatic logic signed [RoundW-1:0] round_q214(input logic signed [ProdW-1:0] p);
      logic signed [ProdW-1:0] s;
      s = p + RoundHalf;
      return s[ProdW-1:RoundShift];
   endfunction

   function automatic logic [15:0] clamp16(input logic signed [RoundW-1:0] v,
                                           input logic signed [RoundW-1:0] lo,
                                           input logic signed [RoundW-1:0] hi);
      logic signed [RoundW-1:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r[15:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/anchor_distance_box_decode.sv =====
// Top level of the anchor distance box decoder: configuration registers and decode pipeline.
// Depends on adbd_pkg and adbd_walk.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one anchor per cycle and walks the stride 8, 16 and 32 grids on its own,
// two anchors per cell, row by row. An anchor whose score is above the threshold, while the
// frame has fewer than MAX_FACES detections, gives one result transfer with a box and five
// keypoints in image-normalized Q2.14; any other anchor gives none. A detection passes three
// registers: an input register, a register after the fourteen parallel 25 by 21 bit
// multipliers, and the result register after rounding and clamping. Without backpressure one
// anchor is taken every cycle; req_stall rises only when all three stages hold detections and
// rsp_stall is high. Configuration must be written only while no detection is in flight; the
// block itself does not enforce this.
module anchor_distance_box_decode #(
   parameter int MAX_FACES = 128
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write,
   input  wire logic [2:0]          csr_index,
   input  wire logic [19:0]         csr_data,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [15:0]         req_score,
   input  wire logic signed [15:0]  req_dist_left,
   input  wire logic signed [15:0]  req_dist_top,
   input  wire logic signed [15:0]  req_dist_right,
   input  wire logic signed [15:0]  req_dist_bottom,
   input  wire logic [31:0]         req_point_offset_0,
   input  wire logic [31:0]         req_point_offset_1,
   input  wire logic [31:0]         req_point_offset_2,
   input  wire logic [31:0]         req_point_offset_3,
   input  wire logic [31:0]         req_point_offset_4,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [6:0]               rsp_face_index,
   output logic [15:0]              rsp_box_score,
   output logic signed [15:0]       rsp_x_min,
   output logic signed [15:0]       rsp_y_min,
   output logic signed [15:0]       rsp_x_max,
   output logic signed [15:0]       rsp_y_max,
   output logic [31:0]              rsp_point_pos_0,
   output logic [31:0]              rsp_point_pos_1,
   output logic [31:0]              rsp_point_pos_2,
   output logic [31:0]              rsp_point_pos_3,
   output logic [31:0]              rsp_point_pos_4
);
   import adbd_pkg::*;

   cfg_type    cfg_ff;
   anchor_type anchor;

   logic                      req_accept;
   logic                      out_free;
   logic                      s2_free;
   logic                      s1_free;

   logic                      s1_valid_ff;
   logic [CellW-1:0]          s1_column_ff;
   logic [CellW-1:0]          s1_row_ff;
   logic [ShiftW-1:0]         s1_shift_ff;
   logic [IndexW-1:0]         s1_face_ff;
   logic [ScoreW-1:0]         s1_score_ff;
   logic signed [OffsetW-1:0] s1_offset_ff [LaneCount];
   logic signed [OffsetW-1:0] offset_in    [LaneCount];

   logic                      s2_valid_ff;
   logic [IndexW-1:0]         s2_face_ff;
   logic [ScoreW-1:0]         s2_score_ff;
   logic signed [ProdW-1:0]   s2_prod_ff [LaneCount];
   logic signed [ProdW-1:0]   prod_in    [LaneCount];

   logic                      rsp_valid_ff;
   logic [15:0]               lane_out [LaneCount];
   logic [15:0]               lane_ff  [LaneCount];
   logic [IndexW-1:0]         rsp_face_ff;
   logic [ScoreW-1:0]         rsp_score_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.score_threshold   <= 16'd26214;
         cfg_ff.image_width       <= 13'd640;
         cfg_ff.image_height      <= 13'd640;
         cfg_ff.width_reciprocal  <= 20'd26214;
         cfg_ff.height_reciprocal <= 20'd26214;
      end else if (csr_write) begin
         case (csr_index)
            CsrScoreThreshold: cfg_ff.score_threshold   <= csr_data[ScoreW-1:0];
            CsrImageWidth:     cfg_ff.image_width       <= csr_data[DimW-1:0];
            CsrImageHeight:    cfg_ff.image_height      <= csr_data[DimW-1:0];
            CsrWidthRecip:     cfg_ff.width_reciprocal  <= csr_data[RecipW-1:0];
            CsrHeightRecip:    cfg_ff.height_reciprocal <= csr_data[RecipW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Each stage moves on when the one after it is empty or emptying.
   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      s2_free    = !s2_valid_ff || out_free;
      s1_free    = !s1_valid_ff || s2_free;
      req_stall  = !s1_free;
      req_accept = req_valid && s1_free;
   end

   adbd_walk #(
      .MAX_FACES(MAX_FACES)
   ) u_walk (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .step   (req_accept),
      .score  (req_score),
      .anchor (anchor)
   );

   // Even lanes are x coordinates, odd lanes y; the first two lanes subtract their distance.
   always_comb begin
      offset_in[0] = req_dist_left;
      offset_in[1] = req_dist_top;
      offset_in[2] = req_dist_right;
      offset_in[3] = req_dist_bottom;
      offset_in[4]  = req_point_offset_0[31:16];
      offset_in[5]  = req_point_offset_0[15:0];
      offset_in[6]  = req_point_offset_1[31:16];
      offset_in[7]  = req_point_offset_1[15:0];
      offset_in[8]  = req_point_offset_2[31:16];
      offset_in[9]  = req_point_offset_2[15:0];
      offset_in[10] = req_point_offset_3[31:16];
      offset_in[11] = req_point_offset_3[15:0];
      offset_in[12] = req_point_offset_4[31:16];
      offset_in[13] = req_point_offset_4[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept && anchor.hit) begin
         s1_valid_ff <= 1'b1;
      end else if (s2_free) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && anchor.hit) begin
         s1_column_ff <= anchor.column;
         s1_row_ff    <= anchor.row;
         s1_shift_ff  <= anchor.shift;
         s1_face_ff   <= anchor.face_index;
         s1_score_ff  <= req_score;
         s1_offset_ff <= offset_in;
      end
   end

   always_comb begin
      logic [CellW-1:0]        grid_pos;
      logic signed [PixW-1:0]  base;
      logic signed [PixW-1:0]  off;
      logic signed [PixW-1:0]  pix;
      logic signed [RecipW:0]  recip;
      for (int i = 0; i < LaneCount; i++) begin
         grid_pos = (i % 2 == 1) ? s1_row_ff : s1_column_ff;
         recip    = (i % 2 == 1) ? $signed({1'b0, cfg_ff.height_reciprocal})
                                 : $signed({1'b0, cfg_ff.width_reciprocal});
         base     = $signed({{(PixW - CellW - 8){1'b0}}, grid_pos, 8'd0});
         off      = PixW'(s1_offset_ff[i]);
         pix      = (i < 2) ? (base - off) : (base + off);
         pix      = pix <<< s1_shift_ff;
         prod_in[i] = pix * recip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_free) begin
         s2_prod_ff  <= prod_in;
         s2_face_ff  <= s1_face_ff;
         s2_score_ff <= s1_score_ff;
      end
   end

   // Box minimums stay at or above zero, box maximums at or below one.
   always_comb begin
      for (int i = 0; i < LaneCount; i++) begin
         if (i < 2) begin
            lane_out[i] = clamp16(round_q214(s2_prod_ff[i]), EdgeLow, SatHigh);
         end else if (i < BoxLanes) begin
            lane_out[i] = clamp16(round_q214(s2_prod_ff[i]), SatLow, OneQ214);
         end else begin
            lane_out[i] = clamp16(round_q214(s2_prod_ff[i]), SatLow, SatHigh);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && out_free) begin
         lane_ff      <= lane_out;
         rsp_face_ff  <= s2_face_ff;
         rsp_score_ff <= s2_score_ff;
      end
   end

   always_comb begin
      rsp_valid       = rsp_valid_ff;
      rsp_face_index  = rsp_face_ff;
      rsp_box_score   = rsp_score_ff;
      rsp_x_min       = $signed(lane_ff[0]);
      rsp_y_min       = $signed(lane_ff[1]);
      rsp_x_max       = $signed(lane_ff[2]);
      rsp_y_max       = $signed(lane_ff[3]);
      rsp_point_pos_0 = {lane_ff[4], lane_ff[5]};
      rsp_point_pos_1 = {lane_ff[6], lane_ff[7]};
      rsp_point_pos_2 = {lane_ff[8], lane_ff[9]};
      rsp_point_pos_3 = {lane_ff[10], lane_ff[11]};
      rsp_point_pos_4 = {lane_ff[12], lane_ff[13]};
   end

endmodule

`default_nettype wire

// ===== hw/rtl/adbd_walk.sv =====
// Anchor grid walker: position over three stride levels, face count and detection decision.
// Depends on adbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adbd_walk #(
   parameter int MAX_FACES = 128
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire adbd_pkg::cfg_type   cfg,
   input  wire logic                step,
   input  wire logic [15:0]         score,
   output adbd_pkg::anchor_type     anchor
);
   import adbd_pkg::*;

   localparam logic [CountW-1:0] MaxCount = CountW'(MAX_FACES);

   logic [CellW-1:0]  column_ff;
   logic [CellW-1:0]  row_ff;
   logic              slot_ff;
   logic [LevelW-1:0] level_ff;
   logic [CountW-1:0] face_ff;

   logic [ShiftW-1:0] shift;
   logic [GridW-1:0]  cols;
   logic [GridW-1:0]  rows;
   logic              col_last;
   logic              row_last;
   logic              level_last;
   logic              hit;

   always_comb begin
      shift      = ShiftW'(level_ff) + BaseShift;
      cols       = grid_dim(cfg.image_width, shift);
      rows       = grid_dim(cfg.image_height, shift);
      // A position left beyond a shrunken grid also counts as last, so it wraps to zero.
      col_last   = (GridW'(column_ff) + GridW'(1)) >= cols;
      row_last   = (GridW'(row_ff) + GridW'(1)) >= rows;
      level_last = level_ff >= LastLevel;
      hit        = (score > cfg.score_threshold) && (face_ff < MaxCount);
      anchor.column     = column_ff;
      anchor.row        = row_ff;
      anchor.shift      = shift;
      anchor.face_index = face_ff[IndexW-1:0];
      anchor.hit        = hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
         slot_ff   <= 1'b0;
         level_ff  <= '0;
         face_ff   <= '0;
      end else if (step) begin
         slot_ff <= ~slot_ff;
         if (slot_ff) begin
            column_ff <= col_last ? '0 : column_ff + CellW'(1);
            if (col_last) begin
               row_ff <= row_last ? '0 : row_ff + CellW'(1);
               if (row_last) begin
                  level_ff <= level_last ? '0 : level_ff + LevelW'(1);
               end
            end
         end
         // The end of the frame clears the count even when its last anchor is a detection.
         if (slot_ff && col_last && row_last && level_last) begin
            face_ff <= '0;
         end else if (hit) begin
            face_ff <= face_ff + CountW'(1);
         end
      end
   end

endmodule

`default_nettype wire
